// ===== hw/rtl/hrd_pkg.sv =====
// shared constants, types and arithmetic step functions for the hessian ridge direction unit
`timescale 1ns / 1ps
package hrd_pkg;

    localparam int IN_WIDTH = 24;
    localparam int IN_FRAC  = 16;
    localparam int VEC_FRAC = 14;
    localparam int VEC_W    = 16;
    localparam int EIG_W    = 26;

    // iteration counts of the square root and divider step pipelines
    localparam int SQ1_STEPS  = 25;
    localparam int DIV1_STEPS = 48;
    localparam int SQ2_STEPS  = 32;
    localparam int DIV2_STEPS = VEC_FRAC + 1;

    localparam longint EIG_MAX = (64'sd1 <<< (EIG_W - 1)) - 64'sd1;
    localparam longint EIG_MIN = -(64'sd1 <<< (EIG_W - 1));

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } sq_pair_t;

    typedef struct packed {
        logic [63:0] rem;
        logic        q;
    } div_pair_t;

    // eigenvalue stage result handed to the direction stage
    typedef struct packed {
        logic signed [48:0]         lam;
        logic                       flat;
        logic signed [IN_WIDTH-1:0] a;
        logic signed [IN_WIDTH-1:0] b;
    } eig_res_t;

    // one digit of the integer square root, bit weight 4^idx
    function automatic sq_pair_t sq_step(input logic [63:0] x, input logic [63:0] r,
                                         input int idx);
        logic [63:0] bitv;
        logic [63:0] t;
        sq_pair_t    o;
        bitv = 64'd1 << (2 * idx);
        t    = r + bitv;
        if (x >= t) begin
            o.x = x - t;
            o.r = (r >> 1) + bitv;
        end else begin
            o.x = x;
            o.r = r >> 1;
        end
        return o;
    endfunction

    // one restoring division step: bring down nb, subtract divisor if it fits
    function automatic div_pair_t div_step(input logic [63:0] rem, input logic nb,
                                           input logic [63:0] d);
        logic [63:0] rs;
        div_pair_t   o;
        rs = {rem[62:0], nb};
        if (rs >= d) begin
            o.rem = rs - d;
            o.q   = 1'b1;
        end else begin
            o.rem = rs;
            o.q   = 1'b0;
        end
        return o;
    endfunction

endpackage

// ===== hw/rtl/hrd_eig_path.sv =====
// eigenvalue pipeline: trace, discriminant root, determinant divide, larger eigenvalue
`timescale 1ns / 1ps
module hrd_eig_path import hrd_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [IN_WIDTH-1:0] dxx,
    input  logic signed [IN_WIDTH-1:0] dxy,
    input  logic signed [IN_WIDTH-1:0] dyy,
    output logic                       out_valid,
    output eig_res_t                   out_res
);

    typedef struct packed {
        logic signed [24:0]         tr;
        logic signed [48:0]         det;
        logic signed [IN_WIDTH-1:0] a;
        logic signed [IN_WIDTH-1:0] b;
    } sq_side_t;

    typedef struct packed {
        logic signed [25:0]         l1;
        logic                       l2_neg;
        logic                       l1_zero;
        logic signed [IN_WIDTH-1:0] a;
        logic signed [IN_WIDTH-1:0] b;
    } dv_side_t;

    // stage a: input capture
    logic                       st_a_v_reg;
    logic signed [IN_WIDTH-1:0] st_a_a_reg, st_a_b_reg, st_a_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_a_v_reg <= 1'b0;
        end else if (en) begin
            st_a_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_a_a_reg <= dxx;
            st_a_b_reg <= dxy;
            st_a_c_reg <= dyy;
        end
    end

    // stage b: trace, differences, cross products
    logic signed [24:0] tr_next, diff_next;
    logic        [23:0] dm_next, babs_next;
    logic signed [47:0] ac_next, bb_next;

    assign tr_next   = 25'(st_a_a_reg) + 25'(st_a_c_reg);
    assign diff_next = 25'(st_a_a_reg) - 25'(st_a_c_reg);
    assign dm_next   = 24'(diff_next[24] ? -diff_next : diff_next);
    assign babs_next = st_a_b_reg[IN_WIDTH-1] ? 24'(-25'(st_a_b_reg)) : 24'(st_a_b_reg);
    assign ac_next   = st_a_a_reg * st_a_c_reg;
    assign bb_next   = st_a_b_reg * st_a_b_reg;

    logic                       st_b_v_reg;
    logic signed [24:0]         st_b_tr_reg;
    logic        [23:0]         st_b_dm_reg;
    logic        [24:0]         st_b_bm2_reg;
    logic signed [47:0]         st_b_ac_reg, st_b_bb_reg;
    logic signed [IN_WIDTH-1:0] st_b_a_reg, st_b_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_b_v_reg <= 1'b0;
        end else if (en) begin
            st_b_v_reg <= st_a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_b_tr_reg  <= tr_next;
            st_b_dm_reg  <= dm_next;
            st_b_bm2_reg <= {babs_next, 1'b0};
            st_b_ac_reg  <= ac_next;
            st_b_bb_reg  <= bb_next;
            st_b_a_reg   <= st_a_a_reg;
            st_b_b_reg   <= st_a_b_reg;
        end
    end

    // stage c: squares of the discriminant terms, determinant
    logic                       st_c_v_reg;
    logic        [47:0]         st_c_dm2_reg;
    logic        [49:0]         st_c_bm22_reg;
    logic signed [48:0]         st_c_det_reg;
    logic signed [24:0]         st_c_tr_reg;
    logic signed [IN_WIDTH-1:0] st_c_a_reg, st_c_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_c_v_reg <= 1'b0;
        end else if (en) begin
            st_c_v_reg <= st_b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_c_dm2_reg  <= st_b_dm_reg * st_b_dm_reg;
            st_c_bm22_reg <= st_b_bm2_reg * st_b_bm2_reg;
            st_c_det_reg  <= 49'(st_b_ac_reg) - 49'(st_b_bb_reg);
            st_c_tr_reg   <= st_b_tr_reg;
            st_c_a_reg    <= st_b_a_reg;
            st_c_b_reg    <= st_b_b_reg;
        end
    end

    // square root of (a-c)^2 + 4b^2, one digit per stage
    logic        sq_v_reg    [0:SQ1_STEPS];
    logic [51:0] sq_x_reg    [0:SQ1_STEPS];
    logic [51:0] sq_r_reg    [0:SQ1_STEPS];
    sq_side_t    sq_side_reg [0:SQ1_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= st_c_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg[0]        <= 52'(st_c_dm2_reg) + 52'(st_c_bm22_reg);
            sq_r_reg[0]        <= '0;
            sq_side_reg[0].tr  <= st_c_tr_reg;
            sq_side_reg[0].det <= st_c_det_reg;
            sq_side_reg[0].a   <= st_c_a_reg;
            sq_side_reg[0].b   <= st_c_b_reg;
        end
    end

    for (genvar i = 0; i < SQ1_STEPS; i++) begin : g_sq
        sq_pair_t sq_next;
        assign sq_next = sq_step(64'(sq_x_reg[i]), 64'(sq_r_reg[i]), SQ1_STEPS - 1 - i);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[i+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[i+1] <= sq_v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_x_reg[i+1]    <= 52'(sq_next.x);
                sq_r_reg[i+1]    <= 52'(sq_next.r);
                sq_side_reg[i+1] <= sq_side_reg[i];
            end
        end
    end

    // l1 from trace and root, then set up det / |l1|
    sq_side_t           sq_out;
    logic        [24:0] root_next, trm_next, l1m_next;
    logic        [25:0] l1sum_next;
    logic        [47:0] detm_next;

    assign sq_out     = sq_side_reg[SQ1_STEPS];
    assign root_next  = sq_r_reg[SQ1_STEPS][24:0];
    assign trm_next   = sq_out.tr[24] ? 25'(-sq_out.tr) : 25'(sq_out.tr);
    assign l1sum_next = 26'(trm_next) + 26'(root_next);
    assign l1m_next   = (sq_out.tr == '0) ? '0 : l1sum_next[25:1];
    assign detm_next  = 48'(sq_out.det[48] ? -sq_out.det : sq_out.det);

    logic        dv_v_reg    [0:DIV1_STEPS];
    logic [24:0] dv_rem_reg  [0:DIV1_STEPS];
    logic [47:0] dv_num_reg  [0:DIV1_STEPS];
    logic [24:0] dv_d_reg    [0:DIV1_STEPS];
    dv_side_t    dv_side_reg [0:DIV1_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= sq_v_reg[SQ1_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0]          <= '0;
            dv_num_reg[0]          <= detm_next;
            dv_d_reg[0]            <= l1m_next;
            dv_side_reg[0].l1      <= sq_out.tr[24] ? -26'(l1m_next) : 26'(l1m_next);
            dv_side_reg[0].l2_neg  <= sq_out.det[48] ^ sq_out.tr[24];
            dv_side_reg[0].l1_zero <= (l1m_next == '0);
            dv_side_reg[0].a       <= sq_out.a;
            dv_side_reg[0].b       <= sq_out.b;
        end
    end

    // quotient bits shift into the low end of the numerator register
    for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_dv
        div_pair_t dv_next;
        assign dv_next = div_step(64'(dv_rem_reg[i]), dv_num_reg[i][47], 64'(dv_d_reg[i]));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[i+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[i+1] <= dv_v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[i+1]  <= 25'(dv_next.rem);
                dv_num_reg[i+1]  <= {dv_num_reg[i][46:0], dv_next.q};
                dv_d_reg[i+1]    <= dv_d_reg[i];
                dv_side_reg[i+1] <= dv_side_reg[i];
            end
        end
    end

    // pick the larger eigenvalue
    dv_side_t           dv_out;
    logic signed [48:0] l1_next, l2_next, q_next;

    assign dv_out  = dv_side_reg[DIV1_STEPS];
    assign l1_next = 49'(dv_out.l1);
    assign q_next  = {1'b0, dv_num_reg[DIV1_STEPS]};
    assign l2_next = dv_out.l1_zero ? '0 : (dv_out.l2_neg ? -q_next : q_next);

    logic     out_valid_reg;
    eig_res_t out_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_v_reg[DIV1_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_res_reg.lam  <= (l1_next > l2_next) ? l1_next : l2_next;
            out_res_reg.flat <= dv_out.l1_zero;
            out_res_reg.a    <= dv_out.a;
            out_res_reg.b    <= dv_out.b;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== hw/rtl/hrd_vec_path.sv =====
// direction pipeline: scaled norm root, component divides, saturation and output register
`timescale 1ns / 1ps
module hrd_vec_path import hrd_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  eig_res_t                in_res,
    output logic                    out_valid,
    output logic signed [VEC_W-1:0] normal_x,
    output logic signed [VEC_W-1:0] normal_y,
    output logic signed [VEC_W-1:0] tangent_x,
    output logic signed [VEC_W-1:0] tangent_y,
    output logic signed [EIG_W-1:0] eigenvalue,
    output logic                    flat
);

    localparam int NUM_W = 31 + VEC_FRAC + 1;

    typedef struct packed {
        logic signed [48:0] lam;
        logic               flat;
        logic        [30:0] bms;
        logic        [30:0] ems;
        logic               ny_zero;
        logic               ny_neg;
    } sq_side_t;

    typedef struct packed {
        logic signed [48:0] lam;
        logic               flat;
        logic               n_zero;
        logic               nx_on;
        logic               ny_zero;
        logic               ny_neg;
        logic        [31:0] n;
    } dv_side_t;

    // stage f: offset from the diagonal term and magnitudes
    logic signed [49:0] e_next;
    assign e_next = 50'(in_res.lam) - 50'(in_res.a);

    logic               st_f_v_reg;
    logic signed [48:0] st_f_lam_reg;
    logic               st_f_flat_reg, st_f_ny_zero_reg, st_f_ny_neg_reg;
    logic        [23:0] st_f_bm_reg;
    logic        [49:0] st_f_em_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_f_v_reg <= 1'b0;
        end else if (en) begin
            st_f_v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_f_lam_reg     <= in_res.lam;
            st_f_flat_reg    <= in_res.flat;
            st_f_bm_reg      <= in_res.b[IN_WIDTH-1] ? 24'(-25'(in_res.b)) : 24'(in_res.b);
            st_f_em_reg      <= 50'(e_next[49] ? -e_next : e_next);
            st_f_ny_zero_reg <= (in_res.b == '0) || (e_next == '0);
            st_f_ny_neg_reg  <= in_res.b[IN_WIDTH-1] ^ e_next[49];
        end
    end

    // stage g: right shift that brings both magnitudes below 2^31
    logic [4:0] k_next;
    always_comb begin
        k_next = '0;
        for (int j = 31; j < 50; j++) begin
            if (st_f_em_reg[j]) begin
                k_next = 5'(j - 30);
            end
        end
    end

    logic               st_g_v_reg;
    logic signed [48:0] st_g_lam_reg;
    logic               st_g_flat_reg, st_g_ny_zero_reg, st_g_ny_neg_reg;
    logic        [23:0] st_g_bm_reg;
    logic        [49:0] st_g_em_reg;
    logic        [4:0]  st_g_k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_g_v_reg <= 1'b0;
        end else if (en) begin
            st_g_v_reg <= st_f_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_g_lam_reg     <= st_f_lam_reg;
            st_g_flat_reg    <= st_f_flat_reg;
            st_g_ny_zero_reg <= st_f_ny_zero_reg;
            st_g_ny_neg_reg  <= st_f_ny_neg_reg;
            st_g_bm_reg      <= st_f_bm_reg;
            st_g_em_reg      <= st_f_em_reg;
            st_g_k_reg       <= k_next;
        end
    end

    // stage h: apply the shift
    logic               st_h_v_reg;
    sq_side_t           st_h_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_h_v_reg <= 1'b0;
        end else if (en) begin
            st_h_v_reg <= st_g_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_h_side_reg.lam     <= st_g_lam_reg;
            st_h_side_reg.flat    <= st_g_flat_reg;
            st_h_side_reg.bms     <= 31'(st_g_bm_reg >> st_g_k_reg);
            st_h_side_reg.ems     <= 31'(st_g_em_reg >> st_g_k_reg);
            st_h_side_reg.ny_zero <= st_g_ny_zero_reg;
            st_h_side_reg.ny_neg  <= st_g_ny_neg_reg;
        end
    end

    // stage i: squares
    logic        st_i_v_reg;
    logic [61:0] st_i_sqb_reg, st_i_sqe_reg;
    sq_side_t    st_i_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_i_v_reg <= 1'b0;
        end else if (en) begin
            st_i_v_reg <= st_h_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_i_sqb_reg  <= st_h_side_reg.bms * st_h_side_reg.bms;
            st_i_sqe_reg  <= st_h_side_reg.ems * st_h_side_reg.ems;
            st_i_side_reg <= st_h_side_reg;
        end
    end

    // norm square root, one digit per stage
    logic        sq_v_reg    [0:SQ2_STEPS];
    logic [62:0] sq_x_reg    [0:SQ2_STEPS];
    logic [63:0] sq_r_reg    [0:SQ2_STEPS];
    sq_side_t    sq_side_reg [0:SQ2_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            sq_v_reg[0] <= st_i_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg[0]    <= 63'(st_i_sqb_reg) + 63'(st_i_sqe_reg);
            sq_r_reg[0]    <= '0;
            sq_side_reg[0] <= st_i_side_reg;
        end
    end

    for (genvar i = 0; i < SQ2_STEPS; i++) begin : g_sq
        sq_pair_t sq_next;
        assign sq_next = sq_step(64'(sq_x_reg[i]), sq_r_reg[i], SQ2_STEPS - 1 - i);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[i+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[i+1] <= sq_v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_x_reg[i+1]    <= 63'(sq_next.x);
                sq_r_reg[i+1]    <= sq_next.r;
                sq_side_reg[i+1] <= sq_side_reg[i];
            end
        end
    end

    // rounded numerators; the quotient is known to fit VEC_FRAC+1 bits
    sq_side_t         sq_out;
    logic [31:0]      n_next;
    logic [NUM_W-1:0] numx_next, numy_next;

    assign sq_out    = sq_side_reg[SQ2_STEPS];
    assign n_next    = sq_r_reg[SQ2_STEPS][31:0];
    assign numx_next = NUM_W'({sq_out.bms, {VEC_FRAC{1'b0}}}) + NUM_W'(n_next >> 1);
    assign numy_next = NUM_W'({sq_out.ems, {VEC_FRAC{1'b0}}}) + NUM_W'(n_next >> 1);

    logic                  dv_v_reg    [0:DIV2_STEPS];
    logic [31:0]           dv_rx_reg   [0:DIV2_STEPS];
    logic [31:0]           dv_ry_reg   [0:DIV2_STEPS];
    logic [DIV2_STEPS-1:0] dv_qx_reg   [0:DIV2_STEPS];
    logic [DIV2_STEPS-1:0] dv_qy_reg   [0:DIV2_STEPS];
    dv_side_t              dv_side_reg [0:DIV2_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= sq_v_reg[SQ2_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rx_reg[0]           <= 32'(numx_next[NUM_W-1:DIV2_STEPS]);
            dv_ry_reg[0]           <= 32'(numy_next[NUM_W-1:DIV2_STEPS]);
            dv_qx_reg[0]           <= numx_next[DIV2_STEPS-1:0];
            dv_qy_reg[0]           <= numy_next[DIV2_STEPS-1:0];
            dv_side_reg[0].lam     <= sq_out.lam;
            dv_side_reg[0].flat    <= sq_out.flat;
            dv_side_reg[0].n_zero  <= (n_next == '0);
            dv_side_reg[0].nx_on   <= (sq_out.bms != '0);
            dv_side_reg[0].ny_zero <= sq_out.ny_zero;
            dv_side_reg[0].ny_neg  <= sq_out.ny_neg;
            dv_side_reg[0].n       <= n_next;
        end
    end

    for (genvar i = 0; i < DIV2_STEPS; i++) begin : g_dv
        div_pair_t dvx_next, dvy_next;
        assign dvx_next = div_step(64'(dv_rx_reg[i]), dv_qx_reg[i][DIV2_STEPS-1],
                                   64'(dv_side_reg[i].n));
        assign dvy_next = div_step(64'(dv_ry_reg[i]), dv_qy_reg[i][DIV2_STEPS-1],
                                   64'(dv_side_reg[i].n));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[i+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[i+1] <= dv_v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rx_reg[i+1]   <= 32'(dvx_next.rem);
                dv_ry_reg[i+1]   <= 32'(dvy_next.rem);
                dv_qx_reg[i+1]   <= {dv_qx_reg[i][DIV2_STEPS-2:0], dvx_next.q};
                dv_qy_reg[i+1]   <= {dv_qy_reg[i][DIV2_STEPS-2:0], dvy_next.q};
                dv_side_reg[i+1] <= dv_side_reg[i];
            end
        end
    end

    // clamp, sign, eigenvalue saturation and output register
    localparam logic [DIV2_STEPS-1:0] VEC_LIM = DIV2_STEPS'(1) << VEC_FRAC;

    dv_side_t              dv_out;
    logic [DIV2_STEPS-1:0] qx_next, qy_next;
    logic signed [VEC_W-1:0] nx_next, ny_next;
    logic signed [48:0]      ev_max_next, ev_min_next;

    assign dv_out      = dv_side_reg[DIV2_STEPS];
    assign qx_next     = (dv_qx_reg[DIV2_STEPS] > VEC_LIM) ? VEC_LIM : dv_qx_reg[DIV2_STEPS];
    assign qy_next     = (dv_qy_reg[DIV2_STEPS] > VEC_LIM) ? VEC_LIM : dv_qy_reg[DIV2_STEPS];
    assign nx_next     = (!dv_out.nx_on || dv_out.n_zero) ? '0 : VEC_W'(qx_next);
    assign ny_next     = (dv_out.ny_zero || dv_out.n_zero) ? '0 :
                         (dv_out.ny_neg ? -VEC_W'(qy_next) : VEC_W'(qy_next));
    assign ev_max_next = 49'(EIG_MAX);
    assign ev_min_next = 49'(EIG_MIN);

    logic                    out_valid_reg;
    logic signed [VEC_W-1:0] normal_x_reg, normal_y_reg, tangent_x_reg, tangent_y_reg;
    logic signed [EIG_W-1:0] eigenvalue_reg;
    logic                    flat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_v_reg[DIV2_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            normal_x_reg  <= nx_next;
            normal_y_reg  <= ny_next;
            tangent_x_reg <= -ny_next;
            tangent_y_reg <= nx_next;
            if (dv_out.lam > ev_max_next) begin
                eigenvalue_reg <= EIG_W'(ev_max_next);
            end else if (dv_out.lam < ev_min_next) begin
                eigenvalue_reg <= EIG_W'(ev_min_next);
            end else begin
                eigenvalue_reg <= EIG_W'(dv_out.lam);
            end
            flat_reg <= dv_out.flat || dv_out.n_zero;
        end
    end

    assign out_valid  = out_valid_reg;
    assign normal_x   = normal_x_reg;
    assign normal_y   = normal_y_reg;
    assign tangent_x  = tangent_x_reg;
    assign tangent_y  = tangent_y_reg;
    assign eigenvalue = eigenvalue_reg;
    assign flat       = flat_reg;

endmodule

// ===== hw/rtl/hessian_ridge_direction_unit.sv =====
// top level of the hessian ridge direction unit
//
//  channel   ports                                     width             transaction
//  -------   ---------------------------------------   ---------------   ----------------
//  input     s_valid s_ready s_dxx s_dxy s_dyy         24 each, signed   one pixel
//  result    m_valid m_ready m_normal_x/_y             16, 16 signed     one direction
//            m_tangent_x/_y m_eigenvalue m_flat        16, 16, 26, 1
//
// one transaction per cycle while results are taken; 133 register stages from input to result,
// set by the two square root units and the two restoring dividers (one digit per stage).
// the whole pipeline advances together whenever the result register is empty or taken,
// so a stall on m_ready freezes every stage and s_ready drops in the same cycle.
// synchronous active-low reset clears only the stage valid bits.
`timescale 1ns / 1ps
module hessian_ridge_direction_unit import hrd_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [IN_WIDTH-1:0] s_dxx,
    input  logic signed [IN_WIDTH-1:0] s_dxy,
    input  logic signed [IN_WIDTH-1:0] s_dyy,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [VEC_W-1:0]    m_normal_x,
    output logic signed [VEC_W-1:0]    m_normal_y,
    output logic signed [VEC_W-1:0]    m_tangent_x,
    output logic signed [VEC_W-1:0]    m_tangent_y,
    output logic signed [EIG_W-1:0]    m_eigenvalue,
    output logic                       m_flat
);

    logic     en;
    logic     eig_valid;
    eig_res_t eig_res;

    // pipeline moves whenever the result register can take a new value
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    hrd_eig_path u_eig (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .dxx       (s_dxx),
        .dxy       (s_dxy),
        .dyy       (s_dyy),
        .out_valid (eig_valid),
        .out_res   (eig_res)
    );

    hrd_vec_path u_vec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (eig_valid),
        .in_res     (eig_res),
        .out_valid  (m_valid),
        .normal_x   (m_normal_x),
        .normal_y   (m_normal_y),
        .tangent_x  (m_tangent_x),
        .tangent_y  (m_tangent_y),
        .eigenvalue (m_eigenvalue),
        .flat       (m_flat)
    );

    a_tangent_rot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tangent_x == -m_normal_y) && (m_tangent_y == m_normal_x))
        else $error("tangent is not the normal turned by 90 degrees");

    a_normal_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_x >= 0) && (m_normal_x <= 16384))
        else $error("normal_x outside unit range");

    a_normal_y_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_y >= -16384) && (m_normal_y <= 16384))
        else $error("normal_y outside unit range");

endmodule
